// File: sv/sha_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sha_pkg;

    localparam logic [60:0] LenLimit = {61{1'b1}};

    localparam logic [31:0] InitWords [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last;
        logic        length_error;
    } t_out_item;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage
`default_nettype wire

// File: sv/sha_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface sha_in_if;
    import sha_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface sha_out_if;
    import sha_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: sv/sha256_stream_hasher_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Plain byte: accepted without dropping ready. A byte that fills a block drops
// ready while the block is compressed: start, 64 rounds, done, chain add.
// End of message: a pad step, then 1 or 2 compressions, then 8 result words
// at one per accepted cycle. One round per cycle.
// Synchronous active-low reset restores initial hash values and counts.
module sha256_stream_hasher_unit
    import sha_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sha_in_if.sink    i_in,
    sha_out_if.source o_out
);
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001, ST_RUN = 6'b000010, ST_ADD = 6'b000100,
        ST_PAD = 6'b001000, ST_EMIT = 6'b010000, ST_ERR = 6'b100000
    } t_state;

    t_state      r_state;
    logic [511:0] r_buf;
    logic [31:0] r_chain [8];
    logic [5:0]  r_pos;
    logic [60:0] r_count;
    logic        r_fin, r_final, r_start;
    logic        n_start;
    logic [2:0]  r_idx;
    logic        done;
    logic [31:0] words [8];
    logic [511:0] pad_blk;
    logic [63:0] bits;

    sha_round u_round (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start), .i_block(r_buf),
        .i_chain(r_chain), .o_done(done), .o_words(words)
    );

    assign bits = {r_count, 3'b000};
    always_comb begin
        pad_blk = r_buf;
        for (int i = 0; i < 64; i++) begin
            if (i > int'(r_pos)) pad_blk[511 - 8*i -: 8] = 8'h00;
        end
        pad_blk[511 - 8*int'(r_pos) -: 8] = 8'h80;
    end

    // kick the round unit on a full block, a pad block or the length-only block
    assign n_start = ((r_state == ST_IDLE) && i_in.valid && i_in.payload.has_byte
                      && (r_count != LenLimit) && (r_pos == 6'd63))
                   || (r_state == ST_PAD)
                   || ((r_state == ST_ADD) && !r_final && !r_fin && (r_pos != 6'd0));

    assign i_in.ready = (r_state == ST_IDLE);
    assign o_out.valid = (r_state == ST_EMIT) || (r_state == ST_ERR);
    assign o_out.payload.digest_word  = (r_state == ST_ERR) ? '0 : r_chain[r_idx];
    assign o_out.payload.word_index   = (r_state == ST_ERR) ? '0 : r_idx;
    assign o_out.payload.last         = (r_state == ST_ERR) || (r_idx == 3'd7);
    assign o_out.payload.length_error = (r_state == ST_ERR);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b0;
            r_state <= ST_IDLE;
            r_chain <= InitWords;
            r_pos   <= '0;
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            r_start <= n_start;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_in.valid) begin
                        r_fin   <= i_in.payload.end_of_message;
                        r_final <= 1'b0;
                        if (i_in.payload.has_byte && r_count == LenLimit) begin
                            r_state <= ST_ERR;
                        end else if (i_in.payload.has_byte) begin
                            r_buf[511 - 8*int'(r_pos) -: 8] <= i_in.payload.data_byte;
                            r_count <= r_count + 61'd1;
                            r_pos   <= r_pos + 6'd1;
                            if (r_pos == 6'd63) begin
                                r_state <= ST_RUN;
                            end else if (i_in.payload.end_of_message) begin
                                r_state <= ST_PAD;
                            end
                        end else if (i_in.payload.end_of_message) begin
                            r_state <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    // append 0x80; length fits only if at most 55 bytes used
                    if (r_pos > 6'd55) begin
                        r_buf   <= pad_blk;
                        r_final <= 1'b0;
                    end else begin
                        r_buf   <= {pad_blk[511:64], bits};
                        r_final <= 1'b1;
                    end
                    r_fin   <= 1'b0;
                    r_state <= ST_RUN;
                end
                ST_RUN: begin
                    if (done) r_state <= ST_ADD;
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) r_chain[i] <= r_chain[i] + words[i];
                    if (r_final) begin
                        r_idx   <= '0;
                        r_state <= ST_EMIT;
                    end else if (r_fin) begin
                        r_state <= ST_PAD;
                    end else if (r_pos != 6'd0) begin
                        // overflow pad block done: length-only block follows
                        r_buf   <= {448'd0, bits};
                        r_pos   <= '0;
                        r_final <= 1'b1;
                        r_state <= ST_RUN;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_EMIT: begin
                    if (o_out.ready) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == 3'd7) begin
                            r_chain <= InitWords;
                            r_pos   <= '0;
                            r_count <= '0;
                            r_state <= ST_IDLE;
                        end
                    end
                end
                ST_ERR: begin
                    if (o_out.ready) r_state <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: sv/sha_round.sv
`timescale 1ns / 1ps
`default_nettype none
// One compression round and one schedule word per cycle; 16-word window.
module sha_round
    import sha_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [511:0] i_block,
    input  wire logic [31:0] i_chain [8],
    output logic             o_done,
    output logic [31:0]      o_words [8]
);
    logic [31:0] r_w [16];
    logic [31:0] r_s [8];
    logic [6:0]  r_cnt;
    logic        r_run;
    logic        r_done;
    logic [31:0] w_new, t1, t2, e, a, x, y;

    assign e = r_s[4];
    assign a = r_s[0];
    assign x = r_w[1];
    assign y = r_w[14];
    assign w_new = r_w[0] + (rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3)) + r_w[9]
                 + (rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10));
    assign t1 = r_s[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
              + ((e & r_s[5]) ^ (~e & r_s[6])) + RoundK[r_cnt[5:0]] + r_w[0];
    assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
              + ((a & r_s[1]) ^ (a & r_s[2]) ^ (r_s[1] & r_s[2]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
        end else if (i_start) begin
            for (int i = 0; i < 16; i++) r_w[i] <= i_block[511 - 32*i -: 32];
            r_s   <= i_chain;
            r_cnt <= '0;
            r_run <= 1'b1;
        end else if (r_run) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
            r_w[15] <= w_new;
            r_s[7] <= r_s[6];
            r_s[6] <= r_s[5];
            r_s[5] <= r_s[4];
            r_s[4] <= r_s[3] + t1;
            r_s[3] <= r_s[2];
            r_s[2] <= r_s[1];
            r_s[1] <= r_s[0];
            r_s[0] <= t1 + t2;
            r_cnt  <= r_cnt + 7'd1;
            if (r_cnt == 7'd63) r_run <= 1'b0;
        end
    end

    // pulse once the last round has been taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= !i_start && r_run && (r_cnt == 7'd63);
        end
    end

    assign o_done  = r_done;
    assign o_words = r_s;
endmodule
`default_nettype wire

// File: sv/sha_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module sha_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  out_index,
    input wire logic        out_last,
    input wire logic        out_err
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("input taken during results");
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_err |-> out_last && out_index == 3'd0)
        else $error("error result malformed");
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_err |-> (out_last == (out_index == 3'd7)))
        else $error("last flag mismatch");
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_ready && !out_last |=> out_valid
            && out_index == $past(out_index) + 3'd1)
        else $error("digest words out of order");
endmodule

bind sha256_stream_hasher_unit sha_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_ready(i_in.ready),
    .out_valid(o_out.valid), .out_ready(o_out.ready),
    .out_index(o_out.payload.word_index), .out_last(o_out.payload.last),
    .out_err(o_out.payload.length_error)
);
`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import sha_pkg::*;

    logic i_clk;
    logic i_rst_n;

    sha_in_if  in_ch();
    sha_out_if out_ch();

    sha256_stream_hasher_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    // predictor state
    logic [31:0] hash_state [8];
    logic [7:0]  blk_bytes [64];
    logic [5:0]  blk_fill;
    logic [60:0] msg_len;

    t_out_item digest_expect [$];
    int        mismatch_count;
    bit        steady_flow;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (steady_flow || roll < 60) return 0;
        if (roll < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    task automatic compress_block();
        logic [31:0] w [64];
        logic [31:0] s [8];
        logic [31:0] t1, t2, x, y;
        for (int i = 0; i < 16; i++)
            w[i] = {blk_bytes[4*i], blk_bytes[4*i+1], blk_bytes[4*i+2], blk_bytes[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            x = w[i-15];
            y = w[i-2];
            w[i] = w[i-16] + (ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3)) + w[i-7]
                 + (ror32(y, 17) ^ ror32(y, 19) ^ (y >> 10));
        end
        s = hash_state;
        for (int i = 0; i < 64; i++) begin
            t1 = s[7] + (ror32(s[4], 6) ^ ror32(s[4], 11) ^ ror32(s[4], 25))
               + ((s[4] & s[5]) ^ (~s[4] & s[6])) + RoundK[i] + w[i];
            t2 = (ror32(s[0], 2) ^ ror32(s[0], 13) ^ ror32(s[0], 22))
               + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
            s[7] = s[6]; s[6] = s[5]; s[5] = s[4]; s[4] = s[3] + t1;
            s[3] = s[2]; s[2] = s[1]; s[1] = s[0]; s[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_state[i] = hash_state[i] + s[i];
    endtask

    task automatic restart_message();
        hash_state = InitWords;
        blk_fill   = '0;
        msg_len    = '0;
    endtask

    task automatic predict_digest(input t_in_item req);
        logic [63:0] bit_len;
        t_out_item   res;
        int          pos;
        if (req.has_byte) begin
            if (msg_len == LenLimit) begin
                // drop byte, message stays open
                res = '{digest_word: '0, word_index: '0, last: 1'b1, length_error: 1'b1};
                digest_expect = {digest_expect, res};
                return;
            end
            blk_bytes[blk_fill] = req.data_byte;
            msg_len  = msg_len + 61'd1;
            blk_fill = blk_fill + 6'd1;
            if (blk_fill == 0) compress_block();
        end
        if (!req.end_of_message) return;
        bit_len = {msg_len, 3'b000};
        pos = blk_fill;
        blk_bytes[pos] = 8'h80;
        pos++;
        if (pos > 56) begin
            while (pos < 64) blk_bytes[pos++] = 8'h00;
            compress_block();
            pos = 0;
        end
        while (pos < 56) blk_bytes[pos++] = 8'h00;
        for (int i = 0; i < 8; i++) blk_bytes[56+i] = bit_len[(7-i)*8 +: 8];
        compress_block();
        for (int i = 0; i < 8; i++) begin
            res = '{digest_word: hash_state[i], word_index: 3'(i),
                    last: (i == 7), length_error: 1'b0};
            digest_expect = {digest_expect, res};
        end
        restart_message();
    endtask

    // present one request and hold it until accepted; valid stays high on return
    task automatic send_request(input logic [7:0] data, input bit has, input bit fin);
        int gap;
        t_in_item req;
        gap = pick_gap();
        if (gap > 0) begin
            in_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req = '{data_byte: data, has_byte: has, end_of_message: fin};
        in_ch.payload = req;
        in_ch.valid   = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_digest(req);
        @(negedge i_clk);
    endtask

    task automatic send_message(input int len, input bit end_carries_byte);
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(19) == 0) send_request(8'($urandom), 1'b0, 1'b0);
            if (end_carries_byte && i == len - 1)
                send_request(8'($urandom), 1'b1, 1'b1);
            else
                send_request(8'($urandom), 1'b1, 1'b0);
        end
        if (!end_carries_byte || len == 0) send_request(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic test_directed();
        send_request(8'hff, 1'b0, 1'b1);    // empty message, data ignored
        send_request(8'h5a, 1'b0, 1'b0);    // idle request
        send_request(8'h00, 1'b1, 1'b1);    // single zero byte with end
        send_request(8'hff, 1'b1, 1'b1);
        send_request("a", 1'b1, 1'b0);
        send_request("b", 1'b1, 1'b0);
        send_request("c", 1'b1, 1'b0);
        send_request(8'h00, 1'b0, 1'b0);
        send_request(8'h00, 1'b0, 1'b1);
        send_request(8'h80, 1'b1, 1'b0);
        send_request(8'h7f, 1'b1, 1'b1);
    endtask

    task automatic test_random_messages(input int budget);
        int sent;
        int len;
        int roll;
        sent = 0;
        while (sent < budget) begin
            roll = $urandom_range(99);
            if (roll < 25) begin
                // lengths around the padding and block boundaries
                case ($urandom_range(6))
                    0: len = 55;
                    1: len = 56;
                    2: len = 63;
                    3: len = 64;
                    4: len = 119;
                    5: len = 120;
                    default: len = 128;
                endcase
            end else begin
                len = $urandom_range(12);
            end
            send_message(len, 1'($urandom_range(1)));
            sent += len + 1;
        end
    endtask

    task automatic test_steady_flow();
        steady_flow = 1'b1;
        send_message(64, 1'b0);
        send_message(56, 1'b1);
        send_message(3, 1'b0);
        steady_flow = 1'b0;
    endtask

    // result side: randomized backpressure
    int stall_left;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready = 1'b0;
            stall_left = 0;
        end else if (stall_left > 0) begin
            out_ch.ready = 1'b0;
            stall_left--;
        end else if (steady_flow || $urandom_range(99) < 70) begin
            out_ch.ready = 1'b1;
        end else begin
            out_ch.ready = 1'b0;
            stall_left = ($urandom_range(9) == 0) ? $urandom_range(60, 20)
                                                  : $urandom_range(3);
        end
    end

    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.payload;
            if (digest_expect.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: word %h index %0d last %b err %b",
                             got.digest_word, got.word_index, got.last, got.length_error);
            end else begin
                want = digest_expect.pop_front();
                if (got.digest_word !== want.digest_word || got.word_index !== want.word_index
                    || got.last !== want.last || got.length_error !== want.length_error) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %h/%0d/%b/%b got %h/%0d/%b/%b",
                                 want.digest_word, want.word_index, want.last,
                                 want.length_error, got.digest_word, got.word_index,
                                 got.last, got.length_error);
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        int drain;
        mismatch_count = 0;
        steady_flow    = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.payload  = '0;
        out_ch.ready   = 1'b0;
        restart_message();
        for (int i = 0; i < 64; i++) blk_bytes[i] = 8'h00;
        i_rst_n = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_messages(230);
        test_steady_flow();
        in_ch.valid = 1'b0;

        drain = 0;
        while (digest_expect.size() != 0 && drain < 100000) begin
            @(negedge i_clk);
            drain++;
        end
        repeat (200) @(negedge i_clk);
        if (mismatch_count == 0 && digest_expect.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: files.f
sv/sha_pkg.sv
sv/sha_if.sv
sv/sha_round.sv
sv/sha256_stream_hasher_unit.sv
sv/sha_checker.sv
test/testbench.sv
